[rtl/rv32_pkg.sv]
// Package for the RV32IM execute core: types, opcodes, CSR addresses.
// No dependencies.
package rv32_pkg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_EXEC,
        ST_MDIV,
        ST_WRITE,
        ST_OUT
    } ctrl_state_t;

    localparam logic [6:0] OP_LUI    = 7'h37;
    localparam logic [6:0] OP_AUIPC  = 7'h17;
    localparam logic [6:0] OP_JAL    = 7'h6F;
    localparam logic [6:0] OP_JALR   = 7'h67;
    localparam logic [6:0] OP_BRANCH = 7'h63;
    localparam logic [6:0] OP_LOAD   = 7'h03;
    localparam logic [6:0] OP_STORE  = 7'h23;
    localparam logic [6:0] OP_IMM    = 7'h13;
    localparam logic [6:0] OP_REG    = 7'h33;
    localparam logic [6:0] OP_SYS    = 7'h73;

    localparam logic [11:0] CSR_MSTATUS = 12'h300;
    localparam logic [11:0] CSR_MTVEC   = 12'h305;
    localparam logic [11:0] CSR_MEPC    = 12'h341;
    localparam logic [11:0] CSR_MCAUSE  = 12'h342;

    localparam logic [31:0] INST_ECALL  = 32'h0000_0073;
    localparam logic [31:0] INST_EBREAK = 32'h0010_0073;
    localparam logic [31:0] INST_MRET   = 32'h3020_0073;
    localparam logic [31:0] CAUSE_ECALL = 32'd11;

    localparam logic [1:0] STAT_DONE  = 2'd0;
    localparam logic [1:0] STAT_WAIT  = 2'd1;
    localparam logic [1:0] STAT_HALT  = 2'd2;
    localparam logic [1:0] STAT_ILL   = 2'd3;

    // controller -> datapath
    typedef struct packed {
        logic capture;
        logic read;
        logic exec;
        logic md_start;
        logic write;
    } dp_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic md_busy;
        logic need_md;
    } dp_stat_t;

endpackage

[rtl/rv32_muldiv.sv]
// Iterative multiply/divide unit: one bit per cycle, 32 steps after start.
// Works on operand magnitudes and fixes signs at the end. No package dependencies.
module rv32_muldiv (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [2:0]  f3,
    input  logic [31:0] a,
    input  logic [31:0] b,
    output logic        busy,
    output logic [31:0] result
);
    logic [5:0]  cnt_reg, cnt_next;
    logic [63:0] acc_reg, acc_next;    // product, or {rem, quot}
    logic [32:0] mcand_reg, mcand_next;
    logic [2:0]  f3_reg, f3_next;
    logic        neg_q_reg, neg_q_next, neg_r_reg, neg_r_next;
    logic        bz_reg, bz_next;
    logic [31:0] a0_reg, a0_next;
    logic [32:0] trial, psum;
    logic [63:0] prod;
    logic        sa, sb, sgn;
    logic [31:0] ua, ub, q, r;

    assign busy = (cnt_reg != 6'd0);

    // load magnitudes on start, then one shift-add or shift-subtract per cycle
    always_comb begin
        sgn = (f3 == 3'd1) || (f3 == 3'd4) || (f3 == 3'd6);
        sa = sgn & a[31];
        sb = sgn & b[31];
        ua = sa ? (32'd0 - a) : a;
        ub = sb ? (32'd0 - b) : b;
        cnt_next = cnt_reg;
        acc_next = acc_reg;
        mcand_next = mcand_reg;
        f3_next = f3_reg;
        neg_q_next = neg_q_reg;
        neg_r_next = neg_r_reg;
        bz_next = bz_reg;
        a0_next = a0_reg;
        trial = acc_reg[63:31] - mcand_reg;
        psum = {1'b0, acc_reg[63:32]} + (acc_reg[0] ? mcand_reg : 33'd0);
        if (start) begin
            cnt_next = 6'd32;
            f3_next = f3;
            a0_next = a;
            bz_next = (b == 32'd0);
            neg_q_next = sa ^ sb;
            neg_r_next = sa;
            acc_next = {32'd0, ua};
            mcand_next = {1'b0, ub};
        end else if (busy) begin
            cnt_next = cnt_reg - 6'd1;
            if (f3_reg[2]) begin
                // restoring division step
                if (!trial[32])
                    acc_next = {trial[31:0], acc_reg[30:0], 1'b1};
                else
                    acc_next = {acc_reg[62:0], 1'b0};
            end else begin
                // shift-add step over the multiplier bits
                acc_next = {psum, acc_reg[31:1]};
            end
        end
        prod = neg_q_reg ? (64'd0 - acc_reg) : acc_reg;
        q = neg_q_reg ? (32'd0 - acc_reg[31:0]) : acc_reg[31:0];
        r = neg_r_reg ? (32'd0 - acc_reg[63:32]) : acc_reg[63:32];
        case (f3_reg)
            3'd0:    result = prod[31:0];
            3'd1,
            3'd3:    result = prod[63:32];
            3'd4,
            3'd5:    result = bz_reg ? 32'hFFFF_FFFF : q;
            3'd6,
            3'd7:    result = bz_reg ? a0_reg : r;
            default: result = 32'd0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= 6'd0;
        end else begin
            cnt_reg <= cnt_next;
        end
        acc_reg <= acc_next;
        mcand_reg <= mcand_next;
        f3_reg <= f3_next;
        neg_q_reg <= neg_q_next;
        neg_r_reg <= neg_r_next;
        bz_reg <= bz_next;
        a0_reg <= a0_next;
    end
endmodule

[rtl/rv32_datapath.sv]
// Datapath: register file memory, CSRs, ALU, branch and memory request logic.
// Depends on rv32_pkg and rv32_muldiv.
module rv32_datapath #(
    parameter int REG_COUNT = 32
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  rv32_pkg::dp_cmd_t cmd,
    output rv32_pkg::dp_stat_t stat,
    input  logic              s_func,
    input  logic [31:0]       s_inst,
    input  logic [31:0]       s_pc,
    input  logic [31:0]       s_load_data,
    output logic [31:0]       m_next_pc,
    output logic              m_mem_valid,
    output logic              m_mem_write,
    output logic [31:0]       m_mem_addr,
    output logic [1:0]        m_mem_size,
    output logic [31:0]       m_mem_wdata,
    output logic [1:0]        m_status,
    output logic [31:0]       m_halt_code
);
    import rv32_pkg::*;

    localparam int IW = $clog2(REG_COUNT);

    // register file with per-entry valid bits so reset reads zero
    logic [31:0] rf_mem [REG_COUNT];
    logic [REG_COUNT-1:0] rf_vld_reg;
    logic [31:0] ra_reg, rb_reg, a0v_reg;
    logic        va_reg, vb_reg, v10_reg;

    logic        func_reg;
    logic [31:0] inst_reg, pc_reg, ld_reg;
    logic [31:0] mstatus_reg, mtvec_reg, mepc_reg, mcause_reg;
    logic [4:0]  pdest_reg;
    logic [2:0]  pkind_reg;
    logic        pvalid_reg;

    logic        we_reg;
    logic [4:0]  wa_reg;
    logic [31:0] wd_reg;

    logic [31:0] next_reg, ma_reg, md_reg, hc_reg;
    logic        mv_reg, mw_reg;
    logic [1:0]  ms_reg, st_reg;

    logic [31:0] a, b, a0v;
    logic [6:0]  op, f7;
    logic [2:0]  f3;
    logic [4:0]  rd, rs1, rs2;
    logic [31:0] immi, imms, immb, immj, immu;
    logic        ill;
    logic        we;
    logic [31:0] wd, nxt, ma, md, hc;
    logic        mv, mw;
    logic [1:0]  ms, st;
    logic        csr_hit;
    logic [31:0] csr_old, csr_new;
    logic [1:0]  csr_sel;
    logic        csr_we, set_pend, clr_pend, do_ecall, do_mret;
    logic [31:0] ldv;
    logic        take, is_md;
    logic [31:0] md_res;
    logic        md_busy;

    rv32_muldiv u_md (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cmd.md_start),
        .f3      (f3),
        .a       (a),
        .b       (b),
        .busy    (md_busy),
        .result  (md_res)
    );

    function automatic logic rf_ok(input logic [4:0] i);
        return (i != 5'd0) && (32'(i) < REG_COUNT);
    endfunction

    assign op = inst_reg[6:0];
    assign f3 = inst_reg[14:12];
    assign f7 = inst_reg[31:25];
    assign rd = inst_reg[11:7];
    assign rs1 = inst_reg[19:15];
    assign rs2 = inst_reg[24:20];
    assign a = va_reg ? ra_reg : 32'd0;
    assign b = vb_reg ? rb_reg : 32'd0;
    assign a0v = v10_reg ? a0v_reg : 32'd0;
    assign immi = {{20{inst_reg[31]}}, inst_reg[31:20]};
    assign imms = {{20{inst_reg[31]}}, inst_reg[31:25], inst_reg[11:7]};
    assign immb = {{19{inst_reg[31]}}, inst_reg[31], inst_reg[7], inst_reg[30:25],
                   inst_reg[11:8], 1'b0};
    assign immj = {{11{inst_reg[31]}}, inst_reg[31], inst_reg[19:12], inst_reg[20],
                   inst_reg[30:21], 1'b0};
    assign immu = {inst_reg[31:12], 12'd0};
    assign is_md = !func_reg && (op == OP_REG) && (f7 == 7'd1) && (f3 != 3'd2);

    assign stat.md_busy = md_busy;
    assign stat.need_md = is_md;

    // decode and execute one word
    always_comb begin
        ill = 1'b0; we = 1'b0; wd = 32'd0; nxt = pc_reg + 32'd4;
        mv = 1'b0; mw = 1'b0; ma = 32'd0; ms = 2'd0; md = 32'd0; st = STAT_DONE;
        hc = 32'd0; take = 1'b0; csr_we = 1'b0; csr_new = 32'd0;
        set_pend = 1'b0; clr_pend = 1'b0; do_ecall = 1'b0; do_mret = 1'b0;
        csr_hit = 1'b1; csr_sel = 2'd0;
        case (inst_reg[31:20])
            CSR_MSTATUS: csr_sel = 2'd0;
            CSR_MTVEC:   csr_sel = 2'd1;
            CSR_MEPC:    csr_sel = 2'd2;
            CSR_MCAUSE:  csr_sel = 2'd3;
            default:     csr_hit = 1'b0;
        endcase
        case (csr_sel)
            2'd0:    csr_old = mstatus_reg;
            2'd1:    csr_old = mtvec_reg;
            2'd2:    csr_old = mepc_reg;
            default: csr_old = mcause_reg;
        endcase
        case (pkind_reg)
            3'd0:    ldv = {{24{ld_reg[7]}}, ld_reg[7:0]};
            3'd1:    ldv = {{16{ld_reg[15]}}, ld_reg[15:0]};
            3'd4:    ldv = {24'd0, ld_reg[7:0]};
            3'd5:    ldv = {16'd0, ld_reg[15:0]};
            default: ldv = ld_reg;
        endcase
        if (func_reg) begin
            if (!pvalid_reg) ill = 1'b1;
            else begin we = 1'b1; wd = ldv; clr_pend = 1'b1; end
        end else begin
            case (op)
                OP_LUI:   begin we = 1'b1; wd = immu; end
                OP_AUIPC: begin we = 1'b1; wd = pc_reg + immu; end
                OP_JAL:   begin we = 1'b1; wd = pc_reg + 32'd4; nxt = pc_reg + immj; end
                OP_JALR: begin
                    if (f3 != 3'd0) ill = 1'b1;
                    else begin
                        we = 1'b1; wd = pc_reg + 32'd4;
                        nxt = (a + immi) & 32'hFFFF_FFFE;
                    end
                end
                OP_BRANCH: begin
                    case (f3)
                        3'd0:    take = (a == b);
                        3'd1:    take = (a != b);
                        3'd4:    take = ($signed(a) < $signed(b));
                        3'd5:    take = !($signed(a) < $signed(b));
                        3'd6:    take = (a < b);
                        3'd7:    take = (a >= b);
                        default: ill = 1'b1;
                    endcase
                    if (take) nxt = pc_reg + immb;
                end
                OP_LOAD: begin
                    if (f3 == 3'd3 || f3 == 3'd6 || f3 == 3'd7) ill = 1'b1;
                    else begin
                        mv = 1'b1; ma = a + immi; ms = f3[1:0]; st = STAT_WAIT;
                        set_pend = 1'b1;
                    end
                end
                OP_STORE: begin
                    if (f3 > 3'd2) ill = 1'b1;
                    else begin
                        mv = 1'b1; mw = 1'b1; ms = f3[1:0]; ma = a + imms;
                        md = (f3 == 3'd0) ? {24'd0, b[7:0]} :
                             (f3 == 3'd1) ? {16'd0, b[15:0]} : b;
                    end
                end
                OP_IMM: begin
                    we = 1'b1;
                    case (f3)
                        3'd0: wd = a + immi;
                        3'd2: wd = {31'd0, $signed(a) < $signed(immi)};
                        3'd3: wd = {31'd0, a < immi};
                        3'd4: wd = a ^ immi;
                        3'd6: wd = a | immi;
                        3'd7: wd = a & immi;
                        3'd1: begin
                            if (f7[6:1] != 6'd0) begin ill = 1'b1; we = 1'b0; end
                            else if (f7[0]) we = 1'b0;
                            else wd = a << rs2;
                        end
                        default: begin
                            if (f7 == 7'h00) wd = a >> rs2;
                            else if (f7 == 7'h20) wd = 32'($signed(a) >>> rs2);
                            else begin ill = 1'b1; we = 1'b0; end
                        end
                    endcase
                end
                OP_REG: begin
                    we = 1'b1;
                    if (f7 == 7'h00) begin
                        case (f3)
                            3'd0:    wd = a + b;
                            3'd1:    wd = a << b[4:0];
                            3'd2:    wd = {31'd0, $signed(a) < $signed(b)};
                            3'd3:    wd = {31'd0, a < b};
                            3'd4:    wd = a ^ b;
                            3'd5:    wd = a >> b[4:0];
                            3'd6:    wd = a | b;
                            default: wd = a & b;
                        endcase
                    end else if (f7 == 7'h20) begin
                        if (f3 == 3'd0) wd = a - b;
                        else if (f3 == 3'd5) wd = 32'($signed(a) >>> b[4:0]);
                        else begin ill = 1'b1; we = 1'b0; end
                    end else if (f7 == 7'h01) begin
                        if (f3 == 3'd2) begin ill = 1'b1; we = 1'b0; end
                        else wd = md_res;
                    end else begin
                        ill = 1'b1; we = 1'b0;
                    end
                end
                OP_SYS: begin
                    if (f3 == 3'd0) begin
                        if (inst_reg == INST_ECALL) begin
                            do_ecall = 1'b1; nxt = mtvec_reg;
                        end else if (inst_reg == INST_EBREAK) begin
                            st = STAT_HALT; hc = a0v;
                        end else if (inst_reg == INST_MRET) begin
                            do_mret = 1'b1; nxt = mepc_reg;
                        end else ill = 1'b1;
                    end else if (f3 == 3'd1 || f3 == 3'd2) begin
                        if (!csr_hit) ill = 1'b1;
                        else begin
                            we = 1'b1; wd = csr_old; csr_we = 1'b1;
                            csr_new = (f3 == 3'd1) ? a : (csr_old | a);
                        end
                    end else ill = 1'b1;
                end
                default: ill = 1'b1;
            endcase
        end
        if (ill) begin
            nxt = pc_reg + 32'd4; mv = 1'b0; mw = 1'b0; ma = 32'd0; ms = 2'd0;
            md = 32'd0; st = STAT_ILL; hc = 32'd0; we = 1'b0; csr_we = 1'b0;
            set_pend = 1'b0; clr_pend = 1'b0; do_ecall = 1'b0; do_mret = 1'b0;
        end
    end

    assign m_next_pc = next_reg;
    assign m_mem_valid = mv_reg;
    assign m_mem_write = mw_reg;
    assign m_mem_addr = ma_reg;
    assign m_mem_size = ms_reg;
    assign m_mem_wdata = md_reg;
    assign m_status = st_reg;
    assign m_halt_code = hc_reg;

    // register file: read in READ, write in WRITE
    always_ff @(posedge aclk) begin
        if (cmd.read) begin
            ra_reg <= rf_mem[rs1[IW-1:0]];
            rb_reg <= rf_mem[rs2[IW-1:0]];
            a0v_reg <= rf_mem[IW'(10)];
        end
        if (cmd.write && we_reg && rf_ok(wa_reg))
            rf_mem[wa_reg[IW-1:0]] <= wd_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rf_vld_reg <= '0;
            va_reg <= 1'b0; vb_reg <= 1'b0; v10_reg <= 1'b0;
            mstatus_reg <= '0; mtvec_reg <= '0; mepc_reg <= '0; mcause_reg <= '0;
            pdest_reg <= '0; pkind_reg <= '0; pvalid_reg <= 1'b0;
            we_reg <= 1'b0;
        end else begin
            if (cmd.read) begin
                va_reg <= rf_ok(rs1) && rf_vld_reg[rs1[IW-1:0]];
                vb_reg <= rf_ok(rs2) && rf_vld_reg[rs2[IW-1:0]];
                v10_reg <= rf_ok(5'd10) && rf_vld_reg[IW'(10)];
            end
            if (cmd.exec) begin
                we_reg <= we;
                wa_reg <= func_reg ? pdest_reg : rd;
                wd_reg <= wd;
                if (csr_we) begin
                    case (csr_sel)
                        2'd0:    mstatus_reg <= csr_new;
                        2'd1:    mtvec_reg <= csr_new;
                        2'd2:    mepc_reg <= csr_new;
                        default: mcause_reg <= csr_new;
                    endcase
                end
                if (do_ecall) begin mepc_reg <= pc_reg; mcause_reg <= CAUSE_ECALL; end
                if (do_mret) mstatus_reg <= {mstatus_reg[31:4], mstatus_reg[7],
                                             mstatus_reg[2:0]};
                if (set_pend) begin pdest_reg <= rd; pkind_reg <= f3; pvalid_reg <= 1'b1; end
                if (clr_pend) pvalid_reg <= 1'b0;
            end
            if (cmd.write && we_reg && rf_ok(wa_reg))
                rf_vld_reg[wa_reg[IW-1:0]] <= 1'b1;
        end
    end

    // capture input word and result word
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            func_reg <= s_func; inst_reg <= s_inst; pc_reg <= s_pc; ld_reg <= s_load_data;
        end
        if (cmd.exec) begin
            next_reg <= nxt; mv_reg <= mv; mw_reg <= mw; ma_reg <= ma; ms_reg <= ms;
            md_reg <= md; st_reg <= st; hc_reg <= hc;
        end
    end
endmodule

[rtl/rv32_ctrl.sv]
// Controller state machine sequencing capture, read, execute, write back and output.
// Depends on rv32_pkg.
module rv32_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    output logic               m_valid,
    input  logic               m_ready,
    output rv32_pkg::dp_cmd_t  cmd,
    input  rv32_pkg::dp_stat_t stat
);
    import rv32_pkg::*;

    ctrl_state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) state_reg <= ST_IDLE;
        else          state_reg <= state_next;
    end

    // advance through the phases of one word
    always_comb begin
        state_next = state_reg;
        cmd = '0;
        s_ready = 1'b0;
        m_valid = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin cmd.capture = 1'b1; state_next = ST_READ; end
            end
            ST_READ: begin
                cmd.read = 1'b1;
                state_next = ST_EXEC;
            end
            ST_EXEC: begin
                if (stat.need_md) begin
                    cmd.md_start = 1'b1; state_next = ST_MDIV;
                end else begin
                    cmd.exec = 1'b1; state_next = ST_WRITE;
                end
            end
            ST_MDIV: begin
                if (!stat.md_busy) begin cmd.exec = 1'b1; state_next = ST_WRITE; end
            end
            ST_WRITE: begin
                cmd.write = 1'b1;
                state_next = ST_OUT;
            end
            ST_OUT: begin
                m_valid = 1'b1;
                if (m_ready) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end
endmodule

[rtl/rv32im_execute_core_top.sv]
// RV32IM execute core top level: controller plus datapath.
// The result word is presented in OUT after the accepted word passes READ, EXEC,
// MDIV (while the bit-serial mul/div unit is busy) and WRITE; a new word is accepted
// only after the previous result is taken. Synchronous active-low reset clears
// registers (per-entry valid bits), CSRs and pending load; no clearing pass.
module rv32im_execute_core_top #(
    parameter int REG_COUNT = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_func,
    input  logic [31:0] s_inst,
    input  logic [31:0] s_pc,
    input  logic [31:0] s_load_data,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_next_pc,
    output logic        m_mem_valid,
    output logic        m_mem_write,
    output logic [31:0] m_mem_addr,
    output logic [1:0]  m_mem_size,
    output logic [31:0] m_mem_wdata,
    output logic [1:0]  m_status,
    output logic [31:0] m_halt_code
);
    import rv32_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;

    rv32_ctrl u_ctrl (
        .aclk (aclk), .aresetn (aresetn),
        .s_valid (s_valid), .s_ready (s_ready),
        .m_valid (m_valid), .m_ready (m_ready),
        .cmd (cmd), .stat (stat)
    );

    rv32_datapath #(.REG_COUNT(REG_COUNT)) u_dp (
        .aclk (aclk), .aresetn (aresetn), .cmd (cmd), .stat (stat),
        .s_func (s_func), .s_inst (s_inst), .s_pc (s_pc), .s_load_data (s_load_data),
        .m_next_pc (m_next_pc), .m_mem_valid (m_mem_valid), .m_mem_write (m_mem_write),
        .m_mem_addr (m_mem_addr), .m_mem_size (m_mem_size), .m_mem_wdata (m_mem_wdata),
        .m_status (m_status), .m_halt_code (m_halt_code)
    );
endmodule
